@@ design/hist_pkg.sv @@
// Shared types, constants and codes of the two-dimensional histogram engine.
// Used by hist_front, hist_fifo, hist_back and histogram_2d_accumulator.
// No dependencies.
`timescale 1ns / 1ps

package hist_pkg;

  // Histogram geometry and counter width
  localparam int unsigned X_BIN_BITS = 8;
  localparam int unsigned Y_BIN_BITS = 8;
  localparam int unsigned COUNT_BITS = 32;

  localparam int unsigned ADDR_BITS  = X_BIN_BITS + Y_BIN_BITS;
  localparam int unsigned MEM_DEPTH  = 1 << ADDR_BITS;

  // Effective bin count limits and their widths
  localparam int unsigned X_LIM      = 1 << X_BIN_BITS;
  localparam int unsigned Y_LIM      = 1 << Y_BIN_BITS;
  localparam int unsigned XN_W       = X_BIN_BITS + 1;
  localparam int unsigned YN_W       = Y_BIN_BITS + 1;

  // Entries of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Request codes on req_type
  localparam logic [2:0] RQ_FILL       = 3'd0;
  localparam logic [2:0] RQ_READ_BIN   = 3'd1;
  localparam logic [2:0] RQ_READ_UNDER = 3'd2;
  localparam logic [2:0] RQ_READ_OVER  = 3'd3;
  localparam logic [2:0] RQ_CLEAR      = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_X_MIN   = 3'd0;
  localparam logic [2:0] CFG_X_SHIFT = 3'd1;
  localparam logic [2:0] CFG_X_BINS  = 3'd2;
  localparam logic [2:0] CFG_Y_MIN   = 3'd3;
  localparam logic [2:0] CFG_Y_SHIFT = 3'd4;
  localparam logic [2:0] CFG_Y_BINS  = 3'd5;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK,
    ST_UNDER,
    ST_OVER,
    ST_RANGE
  } status_e;

  // Operations the back end carries out
  typedef enum logic [2:0] {
    OP_BIN_ADD,
    OP_BIN_READ,
    OP_UNDER_ADD,
    OP_OVER_ADD,
    OP_UNDER_READ,
    OP_OVER_READ,
    OP_CLEAR,
    OP_REJECT
  } op_e;

  // Configuration register set
  typedef struct packed {
    logic [15:0] x_min;
    logic [3:0]  x_shift;
    logic [8:0]  x_bins;
    logic [15:0] y_min;
    logic [3:0]  y_shift;
    logic [8:0]  y_bins;
  } hist_cfg_t;

  // One classified item in the queue
  typedef struct packed {
    op_e                  kind;
    logic [ADDR_BITS-1:0] addr;
    logic [15:0]          weight;
  } q_entry_t;

endpackage

@@ design/hist_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hist_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/hist_front.sv @@
// Front end: takes request transfers, bins the samples and classifies each item.
// Depends on hist_pkg.
`timescale 1ns / 1ps

module hist_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  hist_pkg::hist_cfg_t cfg_i,
  input  logic [2:0]          req_type_i,
  input  logic [15:0]         x_value_i,
  input  logic [15:0]         y_value_i,
  input  logic [15:0]         weight_i,
  input  logic [7:0]          read_x_bin_i,
  input  logic [7:0]          read_y_bin_i,
  input  logic                q_full_i,
  output logic                ready_o,
  output logic                push_o,
  output hist_pkg::q_entry_t  entry_o
);
  import hist_pkg::*;

  localparam int unsigned PROD_W = Y_BIN_BITS + XN_W;

  typedef struct packed {
    logic [2:0]  req;
    logic        under;
    logic [15:0] xi;
    logic [15:0] yi;
    logic [15:0] weight;
  } front_stage_t;

  front_stage_t         st_q, st_d;
  logic                 st_valid_q, st_valid_d;
  logic [15:0]          x_diff, y_diff;
  logic [XN_W-1:0]      xb_n;
  logic [YN_W-1:0]      yb_n;
  logic                 out_of_range;
  logic [PROD_W-1:0]    prod;
  logic [ADDR_BITS-1:0] lin_addr;

  // Step one: offset, shift and underflow test on the incoming sample
  always_comb begin
    x_diff      = x_value_i - cfg_i.x_min;
    y_diff      = y_value_i - cfg_i.y_min;
    st_d.req    = req_type_i;
    st_d.under  = (x_value_i < cfg_i.x_min) || (y_value_i < cfg_i.y_min);
    st_d.weight = weight_i;
    if (req_type_i == RQ_FILL) begin
      st_d.xi = x_diff >> cfg_i.x_shift;
      st_d.yi = y_diff >> cfg_i.y_shift;
    end else begin
      st_d.xi = {8'd0, read_x_bin_i};
      st_d.yi = {8'd0, read_y_bin_i};
    end
  end

  // Stage register advances when the queue has room
  assign push_o  = st_valid_q && !q_full_i;
  assign ready_o = !st_valid_q || !q_full_i;

  always_comb begin
    st_valid_d = st_valid_q;
    if (accept_i) begin
      st_valid_d = 1'b1;
    end else if (push_o) begin
      st_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else begin
      st_valid_q <= st_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      st_q <= st_d;
    end
  end

  // Step two: clamp bin counts, range check and linear address
  always_comb begin
    if (32'(cfg_i.x_bins) > X_LIM) begin
      xb_n = XN_W'(X_LIM);
    end else begin
      xb_n = XN_W'(cfg_i.x_bins);
    end
    if (32'(cfg_i.y_bins) > Y_LIM) begin
      yb_n = YN_W'(Y_LIM);
    end else begin
      yb_n = YN_W'(cfg_i.y_bins);
    end
    out_of_range = (st_q.xi >= 16'(xb_n)) || (st_q.yi >= 16'(yb_n));
    prod     = PROD_W'(st_q.yi[Y_BIN_BITS-1:0]) * PROD_W'(xb_n);
    lin_addr = ADDR_BITS'(prod + PROD_W'(st_q.xi[X_BIN_BITS-1:0]));
  end

  // Classification into a back-end operation
  always_comb begin
    entry_o.addr   = '0;
    entry_o.weight = st_q.weight;
    unique case (st_q.req)
      RQ_FILL: begin
        if (st_q.under) begin
          entry_o.kind = OP_UNDER_ADD;
        end else if (out_of_range) begin
          entry_o.kind = OP_OVER_ADD;
        end else begin
          entry_o.kind = OP_BIN_ADD;
          entry_o.addr = lin_addr;
        end
      end
      RQ_READ_BIN: begin
        if (out_of_range) begin
          entry_o.kind = OP_REJECT;
        end else begin
          entry_o.kind = OP_BIN_READ;
          entry_o.addr = lin_addr;
        end
      end
      RQ_READ_UNDER: entry_o.kind = OP_UNDER_READ;
      RQ_READ_OVER:  entry_o.kind = OP_OVER_READ;
      RQ_CLEAR:      entry_o.kind = OP_CLEAR;
      default:       entry_o.kind = OP_REJECT;
    endcase
  end

endmodule

@@ design/hist_fifo.sv @@
// Short queue of classified items between the front and back ends.
// Depends on hist_pkg.
`timescale 1ns / 1ps

module hist_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hist_pkg::q_entry_t entry_i,
  input  logic               pop_i,
  output hist_pkg::q_entry_t head_o,
  output logic               valid_o,
  output logic               full_o
);
  import hist_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ design/hist_back.sv @@
// Back end: bin memory read-modify-write, totals, clearing pass and result register.
// Depends on hist_pkg and hist_ram.
`timescale 1ns / 1ps

module hist_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clr_req_i,
  input  logic               q_valid_i,
  input  hist_pkg::q_entry_t q_head_i,
  output logic               q_pop_o,
  output logic               clearing_o,
  output logic               done_o,
  output logic [31:0]        read_count_o,
  output logic [1:0]         status_o,
  output logic [15:0]        bin_address_o
);
  import hist_pkg::*;

  localparam int unsigned SUM_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_RMW
  } back_state_e;

  back_state_e           state_q, state_d;
  logic [ADDR_BITS-1:0]  clr_addr_q, clr_addr_d;
  logic                  clr_item_q, clr_item_d;
  logic [COUNT_BITS-1:0] under_q, under_d;
  logic [COUNT_BITS-1:0] over_q, over_d;
  q_entry_t              op_q, op_d;
  logic                  done_q, done_d;
  logic [31:0]           cnt_q, cnt_d;
  status_e               st_q, st_d;
  logic [15:0]           addr_q, addr_d;

  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [ADDR_BITS-1:0]  ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] rmw_sum;

  // Saturating add of a weight to a counter
  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] acc,
                                                    input logic [15:0] w);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(acc) + SUM_W'(w);
    if (sum > SUM_W'(COUNT_MAX)) begin
      return COUNT_MAX;
    end
    return COUNT_BITS'(sum);
  endfunction

  hist_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_bin_mem (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_raddr = q_head_i.addr;
  assign rmw_sum   = sat_add(ram_rdata, op_q.weight);

  // Sequencer: next state, memory control and result
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    clr_item_d = clr_item_q;
    under_d    = under_q;
    over_d     = over_q;
    op_d       = op_q;
    done_d     = 1'b0;
    cnt_d      = cnt_q;
    st_d       = st_q;
    addr_d     = addr_q;
    q_pop_o    = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = clr_addr_q;
    ram_wdata  = '0;

    unique case (state_q)
      // One entry zeroed per cycle
      B_CLEAR: begin
        ram_we     = 1'b1;
        clr_addr_d = ADDR_BITS'(clr_addr_q + 1'b1);
        if (clr_addr_q == '1) begin
          state_d = B_IDLE;
          if (clr_item_q) begin
            done_d = 1'b1;
            cnt_d  = '0;
            st_d   = ST_OK;
            addr_d = '0;
          end
        end
      end
      B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          op_d    = q_head_i;
          cnt_d   = '0;
          st_d    = ST_OK;
          addr_d  = '0;
          unique case (q_head_i.kind)
            OP_BIN_ADD, OP_BIN_READ: begin
              state_d = B_RMW;
            end
            OP_UNDER_ADD: begin
              under_d = sat_add(under_q, q_head_i.weight);
              done_d  = 1'b1;
              cnt_d   = 32'(under_d);
              st_d    = ST_UNDER;
            end
            OP_OVER_ADD: begin
              over_d = sat_add(over_q, q_head_i.weight);
              done_d = 1'b1;
              cnt_d  = 32'(over_d);
              st_d   = ST_OVER;
            end
            OP_UNDER_READ: begin
              done_d = 1'b1;
              cnt_d  = 32'(under_q);
            end
            OP_OVER_READ: begin
              done_d = 1'b1;
              cnt_d  = 32'(over_q);
            end
            OP_CLEAR: begin
              state_d    = B_CLEAR;
              clr_addr_d = '0;
              clr_item_d = 1'b1;
              under_d    = '0;
              over_d     = '0;
            end
            OP_REJECT: begin
              done_d = 1'b1;
              st_d   = ST_RANGE;
            end
            default: begin
              done_d = 1'b1;
              st_d   = ST_RANGE;
            end
          endcase
        end
      end
      // Read data is back: write the sum for a fill, report either way
      B_RMW: begin
        ram_we    = (op_q.kind == OP_BIN_ADD);
        ram_waddr = op_q.addr;
        ram_wdata = rmw_sum;
        done_d    = 1'b1;
        cnt_d     = (op_q.kind == OP_BIN_ADD) ? 32'(rmw_sum) : 32'(ram_rdata);
        st_d      = ST_OK;
        addr_d    = 16'(op_q.addr);
        state_d   = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase

    // Bin count change restarts a full clear with no result
    if (clr_req_i) begin
      state_d    = B_CLEAR;
      clr_addr_d = '0;
      clr_item_d = 1'b0;
      under_d    = '0;
      over_d     = '0;
      q_pop_o    = 1'b0;
      done_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_CLEAR;
      clr_addr_q <= '0;
      clr_item_q <= 1'b0;
      under_q    <= '0;
      over_q     <= '0;
      op_q       <= '0;
      done_q     <= 1'b0;
      cnt_q      <= '0;
      st_q       <= ST_OK;
      addr_q     <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      clr_item_q <= clr_item_d;
      under_q    <= under_d;
      over_q     <= over_d;
      op_q       <= op_d;
      done_q     <= done_d;
      cnt_q      <= cnt_d;
      st_q       <= st_d;
      addr_q     <= addr_d;
    end
  end

  assign clearing_o    = (state_q == B_CLEAR);
  assign done_o        = done_q;
  assign read_count_o  = cnt_q;
  assign status_o      = st_q;
  assign bin_address_o = addr_q;

endmodule

@@ design/histogram_2d_accumulator.sv @@
// Top level of the two-dimensional histogram engine: configuration registers,
// front end, queue and back end. Depends on hist_pkg, hist_front, hist_fifo, hist_back.
//
//   channel   handshake             payload
//   --------  --------------------  ---------------------------------------------------
//   request   start / busy          req_type_i x_value_i y_value_i weight_i
//                                   read_x_bin_i read_y_bin_i
//   result    done_o (one cycle)    read_count_o status_o bin_address_o
//   config    cfg_we_i              cfg_idx_i cfg_data_i
//
// A request transfer is taken when start is high and busy is low. The front stage
// registers the offset and shifted sample, then bins and classifies it and queues up
// to two items. Back end: a total update or read and a rejected read are answered
// directly from the queue head; a bin fill or bin read passes through a read-modify-write
// state, as the bin memory is read, then written through its single write port.
// After reset, on a clear request and on any write of x_bins or y_bins, the back end
// walks the 65536-entry bin memory, one entry per cycle; busy stays high meanwhile.
// Results are presented for one cycle; the receiver cannot stall them.
`timescale 1ns / 1ps

module histogram_2d_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type_i,
  input  logic [15:0] x_value_i,
  input  logic [15:0] y_value_i,
  input  logic [15:0] weight_i,
  input  logic [7:0]  read_x_bin_i,
  input  logic [7:0]  read_y_bin_i,
  output logic        done_o,
  output logic [31:0] read_count_o,
  output logic [1:0]  status_o,
  output logic [15:0] bin_address_o
);
  import hist_pkg::*;

  hist_cfg_t cfg_q, cfg_d;
  logic      bins_write;
  logic      accept;
  logic      front_ready;
  logic      q_push;
  q_entry_t  q_entry;
  logic      q_pop;
  q_entry_t  q_head;
  logic      q_valid;
  logic      q_full;
  logic      back_clearing;

  // Configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_X_MIN:   cfg_d.x_min   = cfg_data_i;
        CFG_X_SHIFT: cfg_d.x_shift = cfg_data_i[3:0];
        CFG_X_BINS:  cfg_d.x_bins  = cfg_data_i[8:0];
        CFG_Y_MIN:   cfg_d.y_min   = cfg_data_i;
        CFG_Y_SHIFT: cfg_d.y_shift = cfg_data_i[3:0];
        CFG_Y_BINS:  cfg_d.y_bins  = cfg_data_i[8:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_min   <= 16'd0;
      cfg_q.x_shift <= 4'd8;
      cfg_q.x_bins  <= 9'd256;
      cfg_q.y_min   <= 16'd0;
      cfg_q.y_shift <= 4'd8;
      cfg_q.y_bins  <= 9'd256;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign bins_write = cfg_we_i && ((cfg_idx_i == CFG_X_BINS) || (cfg_idx_i == CFG_Y_BINS));

  // Request handshake
  assign busy   = !front_ready || back_clearing;
  assign accept = start && !busy;

  hist_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cfg_i        (cfg_q),
    .req_type_i   (req_type_i),
    .x_value_i    (x_value_i),
    .y_value_i    (y_value_i),
    .weight_i     (weight_i),
    .read_x_bin_i (read_x_bin_i),
    .read_y_bin_i (read_y_bin_i),
    .q_full_i     (q_full),
    .ready_o      (front_ready),
    .push_o       (q_push),
    .entry_o      (q_entry)
  );

  hist_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  hist_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clr_req_i     (bins_write),
    .q_valid_i     (q_valid),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .clearing_o    (back_clearing),
    .done_o        (done_o),
    .read_count_o  (read_count_o),
    .status_o      (status_o),
    .bin_address_o (bin_address_o)
  );

  // Checks
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_bins_write_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bins_write |=> busy)
    else $error("bin count write did not start a clearing pass");

  a_no_addr_off_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> (bin_address_o == '0))
    else $error("bin address reported for a result that touched no bin");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_RANGE) |-> (read_count_o == '0))
    else $error("rejected request returned a nonzero count");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for histogram_2d_accumulator: directed and random requests
// across several binning geometries, checked against an in-bench bin/total model.
// Depends on hist_pkg and the histogram_2d_accumulator RTL.
`timescale 1ns / 1ps

module tb_top;
  import hist_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 4_000_000;
  localparam int unsigned IDLE_PCT       = 21;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned RAND_PER_PHASE = 140;
  localparam int unsigned BURST_FILLS    = 60;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] xv;
    logic [15:0] yv;
    logic [15:0] w;
    logic [7:0]  rx;
    logic [7:0]  ry;
  } hist_req_t;

  typedef struct {
    logic [31:0] count;
    status_e     st;
    logic [15:0] addr;
  } hist_res_t;

  // DUT ports, all known from time zero
  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [2:0]  cfg_idx_i    = CFG_X_MIN;
  logic [15:0] cfg_data_i   = '0;
  logic        start        = 1'b0;
  logic        busy;
  logic [2:0]  req_type_i   = RQ_FILL;
  logic [15:0] x_value_i    = '0;
  logic [15:0] y_value_i    = '0;
  logic [15:0] weight_i     = '0;
  logic [7:0]  read_x_bin_i = '0;
  logic [7:0]  read_y_bin_i = '0;
  logic        done_o;
  logic [31:0] read_count_o;
  logic [1:0]  status_o;
  logic [15:0] bin_address_o;

  // Predicted block state
  hist_cfg_t   cfg;
  logic [31:0] bin_mem [MEM_DEPTH];
  logic [31:0] under_tot;
  logic [31:0] over_tot;

  // Traffic bookkeeping
  hist_req_t   req_pending_q[$];
  hist_res_t   result_due_q[$];
  hist_req_t   cur_req;
  int unsigned queued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned err_cnt      = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned clears_left  = 1;
  logic        idle_on      = 1'b1;

  histogram_2d_accumulator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .x_value_i     (x_value_i),
    .y_value_i     (y_value_i),
    .weight_i      (weight_i),
    .read_x_bin_i  (read_x_bin_i),
    .read_y_bin_i  (read_y_bin_i),
    .done_o        (done_o),
    .read_count_o  (read_count_o),
    .status_o      (status_o),
    .bin_address_o (bin_address_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------------
  // Histogram model
  // ---------------------------------------------------------------------------------

  function automatic int unsigned eff_count(logic [8:0] n, int unsigned lim);
    return (n > lim) ? lim : n;
  endfunction

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [15:0] w);
    logic [32:0] s;
    s = {1'b0, a} + w;
    return s[32] ? '1 : s[31:0];
  endfunction

  function automatic void wipe_stores();
    foreach (bin_mem[i]) bin_mem[i] = '0;
    under_tot = '0;
    over_tot  = '0;
  endfunction

  // Apply one request to the model and return the result it must produce
  function automatic hist_res_t apply_request(hist_req_t r);
    hist_res_t   res;
    int unsigned nx, ny, xb, yb, a;
    res.count = '0;
    res.st    = ST_OK;
    res.addr  = '0;
    nx = eff_count(cfg.x_bins, X_LIM);
    ny = eff_count(cfg.y_bins, Y_LIM);
    case (r.kind)
      RQ_FILL: begin
        if (r.xv < cfg.x_min || r.yv < cfg.y_min) begin
          under_tot = sat_sum(under_tot, r.w);
          res.count = under_tot;
          res.st    = ST_UNDER;
        end else begin
          xb = 16'(r.xv - cfg.x_min);
          yb = 16'(r.yv - cfg.y_min);
          xb = xb >> cfg.x_shift;
          yb = yb >> cfg.y_shift;
          if (xb >= nx || yb >= ny) begin
            over_tot  = sat_sum(over_tot, r.w);
            res.count = over_tot;
            res.st    = ST_OVER;
          end else begin
            a = (yb * nx + xb) & (MEM_DEPTH - 1);
            bin_mem[a] = sat_sum(bin_mem[a], r.w);
            res.count  = bin_mem[a];
            res.addr   = 16'(a);
          end
        end
      end
      RQ_READ_BIN: begin
        if (r.rx >= nx || r.ry >= ny) begin
          res.st = ST_RANGE;
        end else begin
          a = (r.ry * nx + r.rx) & (MEM_DEPTH - 1);
          res.count = bin_mem[a];
          res.addr  = 16'(a);
        end
      end
      RQ_READ_UNDER: res.count = under_tot;
      RQ_READ_OVER:  res.count = over_tot;
      RQ_CLEAR:      wipe_stores();
      default:       res.st = ST_RANGE;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------------

  // Bin index in use, leaning toward the first few so bins get hit repeatedly
  function automatic int unsigned pick_bin(int unsigned n);
    if (n == 0) return $urandom_range(0, 255);
    if (n > 4 && $urandom_range(0, 1) != 0) return $urandom_range(0, 3);
    return $urandom_range(0, n - 1);
  endfunction

  // Axis sample: mostly in range, some below the minimum, some past the last bin
  function automatic logic [15:0] pick_value(logic [15:0] lo, logic [3:0] sh, int unsigned n);
    int unsigned v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: begin
        if (n == 0) return 16'($urandom);
        v = lo + (pick_bin(n) << sh) + ($urandom & ((1 << sh) - 1));
      end
      7:       v = (lo > 0) ? $urandom_range(0, lo - 1) : $urandom_range(0, 65535);
      8:       v = lo + (n << sh) + $urandom_range(0, 3);
      default: v = $urandom_range(0, 65535);
    endcase
    return (v > 32'hFFFF) ? 16'($urandom) : 16'(v);
  endfunction

  function automatic hist_req_t random_req();
    hist_req_t   r;
    int unsigned nx, ny, pick;
    nx   = eff_count(cfg.x_bins, X_LIM);
    ny   = eff_count(cfg.y_bins, Y_LIM);
    r.kind = RQ_READ_OVER;
    r.xv = 16'($urandom);
    r.yv = 16'($urandom);
    r.w  = 16'($urandom);
    r.rx = 8'($urandom);
    r.ry = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r.kind = RQ_FILL;
      r.xv   = pick_value(cfg.x_min, cfg.x_shift, nx);
      r.yv   = pick_value(cfg.y_min, cfg.y_shift, ny);
      case ($urandom_range(0, 15))
        0:       r.w = '0;
        1, 2:    r.w = '1;
        default: ;
      endcase
    end else if (pick < 77) begin
      r.kind = RQ_READ_BIN;
      if ($urandom_range(0, 3) != 0) begin
        r.rx = 8'(pick_bin(nx));
        r.ry = 8'(pick_bin(ny));
      end
    end else if (pick < 85) begin
      r.kind = RQ_READ_UNDER;
    end else if (pick < 93) begin
      r.kind = RQ_READ_OVER;
    end else if (pick < 98) begin
      r.kind = RQ_CLEAR + 3'($urandom_range(1, 3));
    end else if (clears_left > 0 && $urandom_range(0, 7) == 0) begin
      // clear walks the whole memory, so keep it rare
      r.kind = RQ_CLEAR;
      clears_left--;
    end
    return r;
  endfunction

  task automatic push_req(logic [2:0] kind, logic [15:0] xv, logic [15:0] yv, logic [15:0] w,
                          logic [7:0] rx, logic [7:0] ry);
    hist_req_t r;
    r = '{kind: kind, xv: xv, yv: yv, w: w, rx: rx, ry: ry};
    req_pending_q.push_back(r);
    queued_cnt++;
  endtask

  // Wait until every request is transferred and answered and the block is idle
  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || result_due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Random traffic with a full drain halfway through
  task automatic run_random(int unsigned n);
    hist_req_t r;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 2) wait_drained();
      r = random_req();
      req_pending_q.push_back(r);
      queued_cnt++;
    end
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_X_MIN:   cfg.x_min   = data;
      CFG_X_SHIFT: cfg.x_shift = data[3:0];
      CFG_X_BINS:  cfg.x_bins  = data[8:0];
      CFG_Y_MIN:   cfg.y_min   = data;
      CFG_Y_SHIFT: cfg.y_shift = data[3:0];
      CFG_Y_BINS:  cfg.y_bins  = data[8:0];
      default: ;
    endcase
    // a bin count change starts a memory wipe
    if (idx == CFG_X_BINS || idx == CFG_Y_BINS) begin
      wipe_stores();
      repeat (2) @(posedge clk_i);
      while (busy) @(posedge clk_i);
    end
  endtask

  // ---------------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        result_due_q.push_back(apply_request(cur_req));
        accepted_cnt++;
      end
      if (!start || !busy) begin
        if (req_pending_q.size() != 0 && !(idle_on && $urandom_range(0, 99) < IDLE_PCT)) begin
          cur_req = req_pending_q.pop_front();
          start        <= 1'b1;
          req_type_i   <= cur_req.kind;
          x_value_i    <= cur_req.xv;
          y_value_i    <= cur_req.yv;
          weight_i     <= cur_req.w;
          read_x_bin_i <= cur_req.rx;
          read_y_bin_i <= cur_req.ry;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    hist_res_t e;
    if (rst_ni && done_o) begin
      if (result_due_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual 0x%0h st %0d addr 0x%0h",
                 $time, read_count_o, status_o, bin_address_o);
      end else begin
        e = result_due_q.pop_front();
        check_field("read_count", e.count, read_count_o);
        check_field("status", 32'(e.st), 32'(status_o));
        check_field("bin_address", 32'(e.addr), 32'(bin_address_o));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("histogram_2d_accumulator verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------------
  initial begin
    cfg = '{x_min: 16'd0, x_shift: 4'd8, x_bins: 9'd256,
            y_min: 16'd0, y_shift: 4'd8, y_bins: 9'd256};
    wipe_stores();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default geometry: corner bins, zero weight, totals, unknown codes, clear
    push_req(RQ_FILL, 16'h0000, 16'h0000, 16'hFFFF, 8'hFF, 8'hFF);
    push_req(RQ_FILL, 16'hFFFF, 16'hFFFF, 16'h0001, 8'h00, 8'h00);
    push_req(RQ_FILL, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
    push_req(RQ_READ_BIN, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
    push_req(RQ_READ_BIN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    push_req(RQ_READ_BIN, 16'h0000, 16'h0000, 16'h0000, 8'h07, 8'h03);
    push_req(RQ_READ_UNDER, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
    push_req(RQ_READ_OVER, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
    push_req(RQ_CLEAR + 3'd1, 16'h1234, 16'h5678, 16'h9ABC, 8'h12, 8'h34);
    push_req(RQ_CLEAR + 3'd2, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
    push_req(RQ_CLEAR + 3'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    push_req(RQ_CLEAR, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
    push_req(RQ_READ_BIN, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
    push_req(RQ_FILL, 16'h1234, 16'hABCD, 16'h5A5A, 8'hA5, 8'h5A);
    push_req(RQ_READ_BIN, 16'h0000, 16'h0000, 16'h0000, 8'h12, 8'hAB);
    run_random(RAND_PER_PHASE);
    wait_drained();

    // Small grid with offsets: underflow and overflow on each axis, range checks
    cfg_write(CFG_X_MIN, 16'd1000);
    cfg_write(CFG_X_SHIFT, 16'd4);
    cfg_write(CFG_X_BINS, 16'd16);
    cfg_write(CFG_Y_MIN, 16'd500);
    cfg_write(CFG_Y_SHIFT, 16'd3);
    cfg_write(CFG_Y_BINS, 16'd8);
    push_req(RQ_FILL, 16'd999, 16'd600, 16'd7, 8'h00, 8'h00);
    push_req(RQ_FILL, 16'd1000, 16'd499, 16'd9, 8'h00, 8'h00);
    push_req(RQ_FILL, 16'd1256, 16'd500, 16'd3, 8'h00, 8'h00);
    push_req(RQ_FILL, 16'd1000, 16'd564, 16'd4, 8'h00, 8'h00);
    push_req(RQ_FILL, 16'd1255, 16'd563, 16'd11, 8'h00, 8'h00);
    push_req(RQ_READ_BIN, 16'h0000, 16'h0000, 16'h0000, 8'd15, 8'd7);
    push_req(RQ_READ_BIN, 16'h0000, 16'h0000, 16'h0000, 8'd16, 8'd0);
    push_req(RQ_READ_BIN, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd8);
    wait_drained();

    // Burst of heavy overflow fills back to back, with no idling
    idle_on = 1'b0;
    for (int unsigned i = 0; i < BURST_FILLS; i++)
      push_req(RQ_FILL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'($urandom), 8'($urandom));
    push_req(RQ_READ_OVER, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
    push_req(RQ_READ_UNDER, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
    wait_drained();
    idle_on = 1'b1;
    run_random(RAND_PER_PHASE);
    wait_drained();

    // Oversized x count (upper data bits set), single y bin at the top of the range
    cfg_write(CFG_X_MIN, 16'd0);
    cfg_write(CFG_X_SHIFT, 16'd0);
    cfg_write(CFG_X_BINS, 16'hFFFF);
    cfg_write(CFG_Y_MIN, 16'hFFFF);
    cfg_write(CFG_Y_SHIFT, 16'd15);
    cfg_write(CFG_Y_BINS, 16'd1);
    push_req(RQ_FILL, 16'd255, 16'hFFFF, 16'd5, 8'h00, 8'h00);
    push_req(RQ_READ_BIN, 16'h0000, 16'h0000, 16'h0000, 8'd255, 8'd0);
    run_random(RAND_PER_PHASE);
    wait_drained();

    // Zero x bins: every fill lands in a total, every bin read is out of range
    cfg_write(CFG_X_MIN, 16'hFFFF);
    cfg_write(CFG_X_SHIFT, 16'd15);
    cfg_write(CFG_X_BINS, 16'd0);
    cfg_write(CFG_Y_MIN, 16'd0);
    cfg_write(CFG_Y_SHIFT, 16'd0);
    cfg_write(CFG_Y_BINS, 16'd256);
    push_req(RQ_FILL, 16'hFFFF, 16'd0, 16'd6, 8'h00, 8'h00);
    push_req(RQ_READ_BIN, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0);
    run_random(RAND_PER_PHASE);
    wait_drained();

    // Odd-sized grid; then retune offsets and shifts, which must keep the contents
    cfg_write(CFG_X_BINS, 16'd200);
    cfg_write(CFG_Y_BINS, 16'd300);
    run_random(RAND_PER_PHASE / 2);
    wait_drained();
    cfg_write(CFG_X_MIN, 16'd300);
    cfg_write(CFG_X_SHIFT, 16'd2);
    cfg_write(CFG_Y_MIN, 16'd40000);
    cfg_write(CFG_Y_SHIFT, 16'd7);
    push_req(RQ_READ_UNDER, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
    push_req(RQ_READ_OVER, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
    run_random(RAND_PER_PHASE / 2);
    wait_drained();

    if (err_cnt == 0 && result_due_q.size() == 0) begin
      $display("histogram_2d_accumulator verification clean");
    end else begin
      $display("histogram_2d_accumulator verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/hist_pkg.sv
design/hist_ram.sv
design/hist_front.sv
design/hist_fifo.sv
design/hist_back.sv
design/histogram_2d_accumulator.sv
dv/tb_top.sv
